>>> hdl/ocpm_pkg.sv
// Shared widths, constants and register codes of the counter-based position map.
`timescale 1ns / 1ps

package ocpm_pkg;

  // Field and word widths.
  localparam int KEY_W      = 10;
  localparam int LEAF_W     = 20;
  localparam int WORD_W     = 64;
  localparam int IC_W       = 8;
  localparam int LIMIT_W    = 9;
  localparam int LBITS_W    = 5;
  localparam int KCOUNT_W   = 11;
  localparam int CFG_IDX_W  = 2;

  // Stream packing.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 4 * LEAF_W + KEY_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
  localparam int OUT_TUSER_W = 2;

  // Default storage geometry.
  localparam int DEF_MAX_KEYS   = 1024;
  localparam int DEF_GROUP_SIZE = 8;

  // Golden-ratio constant of the hash combine.
  localparam logic [WORD_W-1:0] MIX_CONST = 64'h0000_0000_9e37_79b9;

  // Register values after reset.
  localparam logic [WORD_W-1:0]   SEED_RST   = '0;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 9'd256;
  localparam logic [LBITS_W-1:0]  LBITS_RST  = 5'd10;
  localparam logic [KCOUNT_W-1:0] KCOUNT_RST = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HASH_SEED     = 2'd0,
    CFG_COUNTER_LIMIT = 2'd1,
    CFG_LEAF_BITS     = 2'd2,
    CFG_KEY_COUNT     = 2'd3
  } cfg_reg_t;

endpackage

>>> hdl/ocpm_mix_unit.sv
// Shared 64-bit hash-combine step used for every leaf computation.
`timescale 1ns / 1ps

module ocpm_mix_unit (
  input  logic [ocpm_pkg::WORD_W-1:0] v,
  input  logic [ocpm_pkg::WORD_W-1:0] x,
  output logic [ocpm_pkg::WORD_W-1:0] y
);
  import ocpm_pkg::*;

  logic [WORD_W-1:0] sum;

  // v ^ (x + C + (v << 6) + (v >> 2)), all modulo 2^64.
  assign sum = x + MIX_CONST + (v << 6) + (v >> 2);
  assign y   = v ^ sum;

endmodule

>>> hdl/ocpm_row_ram.sv
// Single-port-write, registered-read memory holding one counter row per key group.
`timescale 1ns / 1ps

module ocpm_row_ram #(
  parameter int DEPTH  = 128,
  parameter int WIDTH  = 136,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/oram_counter_position_map.sv
// Top level of the counter-based position map: sequencer, counter rule and output register.
`timescale 1ns / 1ps

// Usage
// The input stream carries one access request per beat: in_tdata[9:0] is the
// key. The output stream returns one result per request: the key's current and
// next leaf and, where a backed-up sibling of the same group was reset, that
// sibling's key and its old and new leaf. Flags travel in out_tuser.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
// A request passes through the key check and division, the split into group and
// offset, the row read, the row update and the hash steps before it reaches the
// output register; the hash steps run a second pass when a sibling is reset, and
// a rejected key goes from the key check straight to the output register.
// The work is done by the single hash-combine unit, which runs five steps per
// pair of leaves, and by the read-modify-write of the group's counter row.
// One request is processed at a time; in_tready is high only when idle. A
// finished result waits in the output register while the next request is
// accepted, and the block holds in its last state if that register is still
// occupied when the following result is ready.
// After reset the block sweeps the counter memory to zero, one row per cycle,
// over ceil(MAX_KEYS / GROUP_SIZE) rows (128 with the defaults); no request is
// accepted during the sweep, configuration writes are.
module oram_counter_position_map #(
  parameter int MAX_KEYS   = ocpm_pkg::DEF_MAX_KEYS,
  parameter int GROUP_SIZE = ocpm_pkg::DEF_GROUP_SIZE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: access_key [9:0], zero padding above
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ocpm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: current_leaf [19:0], next_leaf [39:20], sibling_key [49:40],
  // sibling_old_leaf [69:50], sibling_new_leaf [89:70], zero padding above
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ocpm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: key_error [0], sibling_valid [1]
  output logic [ocpm_pkg::OUT_TUSER_W-1:0]    out_tuser,
  input  logic                                cfg_wr_en,
  input  logic [ocpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ocpm_pkg::WORD_W-1:0]         cfg_data
);
  import ocpm_pkg::*;

  localparam int GROUP_CNT  = (MAX_KEYS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_W      = (GROUP_CNT > 1) ? $clog2(GROUP_CNT) : 1;
  localparam int OFF_W      = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int SK_W       = KEY_W + 1;
  // Reciprocal for key / GROUP_SIZE; the estimate is low by at most one.
  localparam int DIV_SH     = KEY_W + 7;
  localparam int DIV_M      = (1 << DIV_SH) / GROUP_SIZE;

  // One memory row per group: group counter, item counters and backup marks.
  typedef struct packed {
    logic [GROUP_SIZE-1:0]            mark;
    logic [GROUP_SIZE-1:0][IC_W-1:0]  ic;
    logic [WORD_W-1:0]                gc;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_SPLIT, ST_READ, ST_UPDATE, ST_HASH, ST_DONE
  } state_t;

  // Hash steps per leaf pair: seed with key, then counters of leaf A and B.
  typedef enum logic [2:0] {
    HS_KEY, HS_GC_A, HS_IC_A, HS_GC_B, HS_IC_B
  } hstep_t;

  // Configuration registers.
  logic [WORD_W-1:0]   seed_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [LBITS_W-1:0]  lbits_r;
  logic [KCOUNT_W-1:0] kcount_r;

  // Sequencer and request state.
  state_t            state_r, state_nxt;
  hstep_t            step_r;
  logic              phase_r;
  logic [GRP_W-1:0]  clr_addr_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  q_r;
  logic [GRP_W-1:0]  grp_r;
  logic [OFF_W-1:0]  off_r;
  logic [KEY_W-1:0]  base_r;
  logic              err_r;

  // Hash operands captured at the row update.
  logic [WORD_W-1:0] cur_gc_r, next_gc_r, sib_gc_old_r, gc_new_r;
  logic [IC_W-1:0]   cur_ic_r, next_ic_r, sib_ic_r;
  logic [SK_W-1:0]   sib_k_r;
  logic              sib_found_r;
  logic [WORD_W-1:0] vk_r, acc_r;

  // Results.
  logic [LEAF_W-1:0] cur_leaf_r, next_leaf_r, sib_old_leaf_r, sib_new_leaf_r;

  // Output register.
  logic              out_tvalid_r;
  logic              out_err_r, out_sib_r;
  logic [LEAF_W-1:0] out_cur_r, out_next_r, out_sold_r, out_snew_r;
  logic [KEY_W-1:0]  out_skey_r;

  // Memory ports.
  logic              ram_wr_en, ram_rd_en;
  logic [GRP_W-1:0]  ram_wr_addr;
  logic [ROW_W-1:0]  ram_wr_data, ram_rd_data;

  // Combinational helpers.
  logic [31:0]       lim32;
  logic              key_bad;
  logic [31:0]       prod;
  logic [KEY_W-1:0]  q_est, rem_est, grp_sel, rem_sel;
  logic              rem_fix;
  logic [LEAF_W-1:0] leaf_mask;
  logic [WORD_W-1:0] mix_v, mix_x, mix_y;
  logic [LEAF_W-1:0] leaf_val;
  logic              out_free;

  row_t              row_rd, row_upd, row_wr;
  logic [WORD_W-1:0] gc, gm1, gp1, cur_gc, next_gc, gc_new, sib_gc_old;
  logic [IC_W-1:0]   ic, next_ic;
  logic              mk, ovf_taken;
  logic [GROUP_SIZE-1:0] cand;
  logic [OFF_W-1:0]  sib_off;
  logic              sib_found;

  // ---------------------------------------------------------------------------
  // Configuration registers: written whenever the enable is high.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= SEED_RST;
      limit_r  <= LIMIT_RST;
      lbits_r  <= LBITS_RST;
      kcount_r <= KCOUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HASH_SEED:     seed_r   <= cfg_data;
        CFG_COUNTER_LIMIT: limit_r  <= cfg_data[LIMIT_W-1:0];
        CFG_LEAF_BITS:     lbits_r  <= cfg_data[LBITS_W-1:0];
        CFG_KEY_COUNT:     kcount_r <= cfg_data[KCOUNT_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Key check and the split of the key into group and offset.
  // ---------------------------------------------------------------------------
  always_comb begin
    lim32   = (32'(kcount_r) < 32'(MAX_KEYS)) ? 32'(kcount_r) : 32'(MAX_KEYS);
    key_bad = (32'(key_r) >= lim32);
    prod    = 32'(key_r) * 32'(DIV_M);
    q_est   = KEY_W'(prod >> DIV_SH);
    // The estimate may fall one short, so the remainder may reach one group.
    rem_est = key_r - KEY_W'(32'(q_r) * 32'(GROUP_SIZE));
    rem_fix = (rem_est >= KEY_W'(GROUP_SIZE));
    grp_sel = rem_fix ? (q_r + KEY_W'(1)) : q_r;
    rem_sel = rem_fix ? (rem_est - KEY_W'(GROUP_SIZE)) : rem_est;
  end

  // Leaf mask: bits at or above leaf_bits are cleared; the port width caps it.
  always_comb begin
    for (int i = 0; i < LEAF_W; i++) begin
      leaf_mask[i] = (LBITS_W'(i) < lbits_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Counter rule on the group's row, followed by the sibling reset.
  // ---------------------------------------------------------------------------
  always_comb begin
    row_rd  = row_t'(ram_rd_data);
    row_upd = row_rd;
    gc      = row_rd.gc;
    ic      = row_rd.ic[off_r];
    mk      = row_rd.mark[off_r];
    gm1     = gc - WORD_W'(1);
    gp1     = gc + WORD_W'(1);
    ovf_taken = 1'b0;

    if (mk) begin
      // A reset of the group is pending for this key.
      cur_gc  = gm1;
      next_gc = gc;
      next_ic = '0;
      row_upd.mark[off_r] = 1'b0;
    end else if ((LIMIT_W'(ic) + LIMIT_W'(1)) >= limit_r) begin
      // Item counter overflow: advance the group and mark every sibling below MAX_KEYS.
      ovf_taken = 1'b1;
      cur_gc  = gc;
      next_gc = gp1;
      next_ic = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        if ((OFF_W'(i) != off_r) && ((32'(base_r) + 32'(i)) < 32'(MAX_KEYS))) begin
          row_upd.mark[i] = 1'b1;
        end
      end
    end else begin
      cur_gc  = gc;
      next_gc = gc;
      next_ic = ic + IC_W'(1);
    end
    gc_new             = next_gc;
    row_upd.gc         = gc_new;
    row_upd.ic[off_r]  = next_ic;
    sib_gc_old         = ovf_taken ? gc : gm1;

    // Lowest marked sibling that lies inside the key range.
    for (int i = 0; i < GROUP_SIZE; i++) begin
      cand[i] = row_upd.mark[i] && ((32'(base_r) + 32'(i)) < lim32);
    end
    sib_found = |cand;
    sib_off   = '0;
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (cand[i]) begin
        sib_off = OFF_W'(i);
      end
    end

    row_wr = row_upd;
    if (sib_found) begin
      row_wr.ic[sib_off]   = '0;
      row_wr.mark[sib_off] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Operand selection for the shared hash unit.
  // ---------------------------------------------------------------------------
  always_comb begin
    mix_v = acc_r;
    mix_x = '0;
    unique case (step_r)
      HS_KEY: begin
        mix_v = seed_r;
        mix_x = phase_r ? WORD_W'(sib_k_r) : WORD_W'(key_r);
      end
      HS_GC_A: begin
        mix_v = vk_r;
        mix_x = phase_r ? sib_gc_old_r : cur_gc_r;
      end
      HS_IC_A: begin
        mix_x = phase_r ? WORD_W'(sib_ic_r) : WORD_W'(cur_ic_r);
      end
      HS_GC_B: begin
        mix_v = vk_r;
        mix_x = phase_r ? gc_new_r : next_gc_r;
      end
      HS_IC_B: begin
        mix_x = phase_r ? '0 : WORD_W'(next_ic_r);
      end
      default: begin
        mix_x = '0;
      end
    endcase
  end

  ocpm_mix_unit u_mix (
    .v (mix_v),
    .x (mix_x),
    .y (mix_y)
  );

  assign leaf_val = mix_y[LEAF_W-1:0] & leaf_mask;

  // ---------------------------------------------------------------------------
  // Counter memory: zero sweep after reset, then a read and a write per in-range request.
  // ---------------------------------------------------------------------------
  assign ram_wr_en   = (state_r == ST_CLEAR) || (state_r == ST_UPDATE);
  assign ram_wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : grp_r;
  assign ram_wr_data = (state_r == ST_CLEAR) ? '0 : ROW_W'(row_wr);
  assign ram_rd_en   = (state_r == ST_READ);

  ocpm_row_ram #(
    .DEPTH  (GROUP_CNT),
    .WIDTH  (ROW_W),
    .ADDR_W (GRP_W)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (grp_r),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == GRP_W'(GROUP_CNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:    state_nxt = key_bad ? ST_DONE : ST_SPLIT;
      ST_SPLIT:  state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_HASH;
      ST_HASH: begin
        if ((step_r == HS_IC_B) && (phase_r || !sib_found_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      step_r       <= HS_KEY;
      phase_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // A result loaded in ST_DONE takes the place of the one just taken.
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + GRP_W'(1);
        end
        ST_IDLE: begin
          key_r <= in_tdata[KEY_W-1:0];
        end
        ST_DIV: begin
          err_r <= key_bad;
          q_r   <= q_est;
        end
        ST_SPLIT: begin
          grp_r  <= GRP_W'(grp_sel);
          off_r  <= OFF_W'(rem_sel);
          base_r <= key_r - rem_sel;
        end
        ST_READ: begin
          step_r  <= HS_KEY;
          phase_r <= 1'b0;
        end
        ST_UPDATE: begin
          cur_gc_r     <= cur_gc;
          cur_ic_r     <= ic;
          next_gc_r    <= next_gc;
          next_ic_r    <= next_ic;
          gc_new_r     <= gc_new;
          sib_gc_old_r <= sib_gc_old;
          sib_ic_r     <= row_upd.ic[sib_off];
          sib_k_r      <= SK_W'(base_r) + SK_W'(sib_off);
          sib_found_r  <= sib_found;
        end
        ST_HASH: begin
          unique case (step_r)
            HS_KEY: begin
              vk_r   <= mix_y;
              step_r <= HS_GC_A;
            end
            HS_GC_A: begin
              acc_r  <= mix_y;
              step_r <= HS_IC_A;
            end
            HS_IC_A: begin
              if (phase_r) begin
                sib_old_leaf_r <= leaf_val;
              end else begin
                cur_leaf_r <= leaf_val;
              end
              step_r <= HS_GC_B;
            end
            HS_GC_B: begin
              acc_r  <= mix_y;
              step_r <= HS_IC_B;
            end
            HS_IC_B: begin
              if (phase_r) begin
                sib_new_leaf_r <= leaf_val;
              end else begin
                next_leaf_r <= leaf_val;
              end
              // Second pass for the sibling, if one was reset.
              phase_r <= !phase_r && sib_found_r;
              step_r  <= HS_KEY;
            end
            default: begin
              step_r <= HS_KEY;
            end
          endcase
        end
        ST_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_err_r    <= err_r;
            out_sib_r    <= !err_r && sib_found_r;
            out_cur_r    <= err_r ? '0 : cur_leaf_r;
            out_next_r   <= err_r ? '0 : next_leaf_r;
            out_skey_r   <= (!err_r && sib_found_r) ? sib_k_r[KEY_W-1:0] : '0;
            out_sold_r   <= (!err_r && sib_found_r) ? sib_old_leaf_r : '0;
            out_snew_r   <= (!err_r && sib_found_r) ? sib_new_leaf_r : '0;
          end
        end
        default: begin
          step_r <= HS_KEY;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Ports.
  // ---------------------------------------------------------------------------
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_snew_r, out_sold_r, out_skey_r,
                       out_next_r, out_cur_r};
  assign out_tuser  = {out_sib_r, out_err_r};

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the counter-based position map: random streams checked against a predictor.
`timescale 1ns / 1ps

// Each access request carries one key. The testbench keeps its own copy of
// the group counters, item counters and backup marks, works out the leaves of
// every accepted request and compares each returned result with the oldest
// prediction. The run goes through a short directed part and then a series
// of random phases, each under its own register settings. Both stream sides
// idle and stall at random throughout.
module testbench;
  import ocpm_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int NUM_KEYS       = DEF_MAX_KEYS;
  localparam int GRP_SIZE       = DEF_GROUP_SIZE;
  localparam int GROUP_CNT      = (NUM_KEYS + GRP_SIZE - 1) / GRP_SIZE;
  // The clearing sweep after reset, a single request, the sender gaps and the
  // receiver stalls all last far less than WATCHDOG_LIMIT, so a run of that
  // many quiet cycles can only mean a hang.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct {
    logic              key_error;
    logic [LEAF_W-1:0] current_leaf;
    logic [LEAF_W-1:0] next_leaf;
    logic              sibling_valid;
    logic [KEY_W-1:0]  sibling_key;
    logic [LEAF_W-1:0] sibling_old_leaf;
    logic [LEAF_W-1:0] sibling_new_leaf;
  } access_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [WORD_W-1:0]      cfg_data = '0;

  oram_counter_position_map u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor copy of the register file.
  logic [WORD_W-1:0]   seed_m   = SEED_RST;
  logic [LIMIT_W-1:0]  limit_m  = LIMIT_RST;
  logic [LBITS_W-1:0]  lbits_m  = LBITS_RST;
  logic [KCOUNT_W-1:0] kcount_m = KCOUNT_RST;

  // Predictor copy of the counter stores.
  logic [WORD_W-1:0] group_ctr [GROUP_CNT];
  logic [IC_W-1:0]   item_ctr  [NUM_KEYS];
  logic              backup    [NUM_KEYS];

  logic [KEY_W-1:0] pending_keys [$];
  access_result_t   expected_leaves [$];

  int issued_count   = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int mismatch_count = 0;

  // Sender burst shaping.
  int burst_left = 1;
  int gap_left   = 0;
  bit drain_hold = 1'b0;

  // Receiver stall pattern.
  logic [15:0] rx_cycle = '0;
  int          rx_mode  = 0;

  int idle_cycles = 0;

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] v,
                                                 input logic [WORD_W-1:0] x);
    return v ^ (x + MIX_CONST + (v << 6) + (v >> 2));
  endfunction

  // Leaf of a key for a given pair of counters under the current settings.
  // Leaf widths above the supported maximum are treated as the maximum.
  function automatic logic [LEAF_W-1:0] leaf_hash(input logic [KEY_W-1:0] key,
                                                  input logic [WORD_W-1:0] gc,
                                                  input logic [IC_W-1:0] ic);
    logic [WORD_W-1:0] v;
    int unsigned       bits;
    bits = (lbits_m > LEAF_W) ? LEAF_W : lbits_m;
    v = mix_word(seed_m, WORD_W'(key));
    v = mix_word(v, gc);
    v = mix_word(v, WORD_W'(ic));
    return LEAF_W'(v & ((64'd1 << bits) - 64'd1));
  endfunction

  // Applies the counter rule for one accepted request and queues the result
  // it must produce.
  task automatic predict_access(input logic [KEY_W-1:0] key);
    access_result_t    res;
    int unsigned       key_limit;
    int unsigned       grp;
    int unsigned       off;
    int unsigned       k;
    logic [WORD_W-1:0] gc;
    logic [WORD_W-1:0] cur_gc;
    logic [WORD_W-1:0] nxt_gc;
    logic [IC_W-1:0]   ic;
    logic [IC_W-1:0]   nxt_ic;
    bit                found;
    res = '{default: '0};
    key_limit = (kcount_m < NUM_KEYS) ? kcount_m : NUM_KEYS;
    if (key >= key_limit) begin
      // Rejected keys leave every store untouched.
      res.key_error = 1'b1;
    end else begin
      grp = key / GRP_SIZE;
      off = key % GRP_SIZE;
      gc = group_ctr[grp];
      ic = item_ctr[key];
      cur_gc = gc;
      if (backup[key]) begin
        // A pending backup: the block still sits under the previous group
        // counter value, which wraps to all ones when the group counter is zero.
        nxt_ic = '0;
        nxt_gc = gc;
        cur_gc = gc - 64'd1;
        backup[key] = 1'b0;
      end else if (int'(ic) + 1 >= int'(limit_m)) begin
        // Item counter overflow: the group advances and every sibling is marked.
        nxt_ic = '0;
        nxt_gc = gc + 64'd1;
        group_ctr[grp] = nxt_gc;
        for (int i = 0; i < GRP_SIZE; i++) begin
          if (i != off) backup[grp * GRP_SIZE + i] = 1'b1;
        end
      end else begin
        // Plain increment; above a limit of 256 the counter simply wraps.
        nxt_ic = ic + 8'd1;
        nxt_gc = gc;
      end
      item_ctr[key] = nxt_ic;
      res.current_leaf = leaf_hash(key, cur_gc, ic);
      res.next_leaf    = leaf_hash(key, nxt_gc, nxt_ic);

      // The lowest marked sibling still in range is brought up to date.
      gc = group_ctr[grp];
      found = 1'b0;
      for (int i = 0; i < GRP_SIZE; i++) begin
        k = grp * GRP_SIZE + i;
        if (!found && k < key_limit && backup[k]) begin
          found = 1'b1;
          res.sibling_valid    = 1'b1;
          res.sibling_key      = KEY_W'(k);
          res.sibling_old_leaf = leaf_hash(KEY_W'(k), gc - 64'd1, item_ctr[k]);
          res.sibling_new_leaf = leaf_hash(KEY_W'(k), gc, '0);
          item_ctr[k] = '0;
          backup[k] = 1'b0;
        end
      end
    end
    expected_leaves.insert(expected_leaves.size(), res);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Sender: requests leave the pending queue in bursts of random length with
  // random gaps between them. Now and then the sender holds back until every
  // request already accepted has been answered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_access(in_tdata[KEY_W-1:0]);
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (drain_hold) begin
          if (checked_count == accepted_count) drain_hold = 1'b0;
          in_tvalid <= 1'b0;
        end else if (pending_keys.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'(pending_keys.pop_front());
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            drain_hold = ($urandom_range(0, 15) == 0);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: when rx_cycle[5:0] is zero a stall pattern is drawn from always ready,
  // coin tosses, mostly stalled, a short periodic stall and one long stall.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (rx_cycle[5:0] == 6'd0) rx_mode = $urandom_range(0, 4);
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= ($urandom_range(0, 3) == 0);
      end
      3: begin
        out_tready <= (rx_cycle % 11) >= 6;
      end
      default: begin
        out_tready <= rx_cycle[5:0] > 6'd32;
      end
    endcase
  end

  // Result checker.
  always @(posedge clk) begin
    access_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_leaves.size() == 0) begin
        $error("result returned with no request outstanding: tdata 0x%0h tuser 0x%0h",
               out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        exp_res = expected_leaves.pop_front();
        check_field("key_error", 64'(exp_res.key_error), 64'(out_tuser[0]));
        check_field("sibling_valid", 64'(exp_res.sibling_valid), 64'(out_tuser[1]));
        check_field("current_leaf", 64'(exp_res.current_leaf), 64'(out_tdata[19:0]));
        check_field("next_leaf", 64'(exp_res.next_leaf), 64'(out_tdata[39:20]));
        check_field("sibling_key", 64'(exp_res.sibling_key), 64'(out_tdata[49:40]));
        check_field("sibling_old_leaf", 64'(exp_res.sibling_old_leaf),
                    64'(out_tdata[69:50]));
        check_field("sibling_new_leaf", 64'(exp_res.sibling_new_leaf),
                    64'(out_tdata[89:70]));
        checked_count++;
      end
    end
  end

  // Watchdog on cycles with no handshake on either stream.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_key(input int unsigned key);
    pending_keys.insert(pending_keys.size(), KEY_W'(key));
    issued_count++;
  endtask

  // Waits until every queued request has been answered.
  task automatic wait_drained();
    while (checked_count != issued_count) @(posedge clk);
  endtask

  // Writes all four registers back to back; only called while idle.
  task automatic program_regs(input logic [WORD_W-1:0] seed, input logic [LIMIT_W-1:0] lim,
                              input logic [LBITS_W-1:0] lbits,
                              input logic [KCOUNT_W-1:0] kcount);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_HASH_SEED;
    cfg_data  <= seed;
    @(posedge clk);
    cfg_index <= CFG_COUNTER_LIMIT;
    cfg_data  <= WORD_W'(lim);
    @(posedge clk);
    cfg_index <= CFG_LEAF_BITS;
    cfg_data  <= WORD_W'(lbits);
    @(posedge clk);
    cfg_index <= CFG_KEY_COUNT;
    cfg_data  <= WORD_W'(kcount);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seed_m   = seed;
    limit_m  = lim;
    lbits_m  = lbits;
    kcount_m = kcount;
  endtask

  initial begin
    logic [WORD_W-1:0]   seed;
    logic [LIMIT_W-1:0]  lim;
    logic [LBITS_W-1:0]  lbits;
    logic [KCOUNT_W-1:0] kcount;
    int unsigned         key_limit;
    int unsigned         hot_grp [2];
    int unsigned         hot_key;
    int unsigned         n_items;
    int unsigned         pick;

    for (int g = 0; g < GROUP_CNT; g++) group_ctr[g] = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      item_ctr[k] = '0;
      backup[k]   = 1'b0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Settings after reset: key extremes and alternating bit patterns.
    queue_key(0);
    queue_key(1023);
    queue_key(10'h2AA);
    queue_key(10'h155);
    queue_key(0);
    wait_drained();

    // Limit of one, so every plain access overflows; twelve keys in use, so
    // the marked keys 12 to 15 must never be chosen for a sibling reset.
    program_regs('1, 9'd1, 5'd20, 11'd12);
    queue_key(0);
    queue_key(3);
    queue_key(0);
    queue_key(9);
    queue_key(11);
    queue_key(12);
    queue_key(1023);
    queue_key(8);
    wait_drained();

    // Limit of zero with zero leaf bits, and a key count beyond the store.
    program_regs(64'h0123_4567_89AB_CDEF, 9'd0, 5'd0, 11'd2047);
    queue_key(16);
    queue_key(17);
    queue_key(16);
    queue_key(1023);
    queue_key(1016);
    wait_drained();

    // A limit that can never be reached, leaf bits above the maximum and a
    // single key in use.
    program_regs({$urandom, $urandom}, 9'd300, 5'd31, 11'd1);
    queue_key(0);
    queue_key(0);
    queue_key(1);
    wait_drained();

    // Random phases. Most requests hit two hot groups so that overflows,
    // backups and sibling resets come often; the rest are rejected keys and
    // keys from anywhere.
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        // One key hammered under a limit above 256, so its item counter wraps.
        seed    = {$urandom, $urandom};
        lim     = LIMIT_W'($urandom_range(257, 511));
        lbits   = LBITS_W'(LEAF_W);
        kcount  = KCOUNT_RST;
        n_items = 280;
      end else begin
        case ($urandom_range(0, 5))
          0:       seed = '0;
          1:       seed = '1;
          default: seed = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 7))
          0:       lim = 9'd0;
          1:       lim = 9'd256;
          2:       lim = LIMIT_W'($urandom_range(257, 511));
          default: lim = LIMIT_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 5))
          0:       lbits = 5'd0;
          1:       lbits = LBITS_W'($urandom_range(21, 31));
          2:       lbits = LBITS_W'(LEAF_W);
          default: lbits = LBITS_W'($urandom_range(1, 19));
        endcase
        case ($urandom_range(0, 4))
          0:       kcount = KCOUNT_RST;
          1:       kcount = KCOUNT_W'($urandom_range(1025, 2047));
          2:       kcount = KCOUNT_W'($urandom_range(1, 64));
          default: kcount = KCOUNT_W'($urandom_range(65, 1024));
        endcase
        n_items = 130;
      end
      program_regs(seed, lim, lbits, kcount);

      key_limit  = (kcount < NUM_KEYS) ? kcount : NUM_KEYS;
      hot_grp[0] = $urandom_range(0, (key_limit - 1) / GRP_SIZE);
      hot_grp[1] = $urandom_range(0, (key_limit - 1) / GRP_SIZE);
      hot_key    = $urandom_range(0, key_limit - 1);
      for (int i = 0; i < n_items; i++) begin
        pick = $urandom_range(0, 19);
        if (p == 3 && pick != 0) begin
          queue_key(hot_key);
        end else if (pick < 16) begin
          queue_key(hot_grp[pick % 2] * GRP_SIZE + $urandom_range(0, GRP_SIZE - 1));
        end else if (pick < 18 && key_limit < NUM_KEYS) begin
          queue_key($urandom_range(key_limit, NUM_KEYS - 1));
        end else begin
          queue_key($urandom_range(0, NUM_KEYS - 1));
        end
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_leaves.size() != 0) begin
      $error("%0d predicted results never returned", expected_leaves.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
